// ===== hdl/bpc_pkg.sv =====
// Shared types, widths and fixed-point helpers for the backstepping position controller.
// Depends on nothing; every other file in hdl/ uses it.
package bpc_pkg;

  // Q(WORD_W-FRAC_W).FRAC_W data words
  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int GAIN_A_W   = 32;   // alpha_one, alpha_two
  localparam int LIM_W      = 17;   // sat_limit
  localparam int OG_W       = 18;   // out_gain
  localparam int CTRL_W     = 18;   // control_out
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int SUM_W = WORD_W + 2;              // three-term sums
  localparam int MUL_W = GAIN_A_W + 1 + WORD_W;   // unsigned gain times signed word
  localparam int YP_W  = OG_W + CTRL_W;           // output gain product

  // pipeline depth of each section
  localparam int ERR_STAGES = 6;
  localparam int LAW_STAGES = 3;
  localparam int OUT_STAGES = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [MUL_W-1:0]  prod_t;
  typedef logic signed [YP_W-1:0]   yprod_t;
  typedef logic signed [CTRL_W-1:0] ctrl_t;
  typedef logic [GAIN_A_W-1:0]      again_t;
  typedef logic [LIM_W-1:0]         lim_t;
  typedef logic signed [OG_W-1:0]   ogain_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_ONE,
    REG_ALPHA_TWO,
    REG_SAT_LIMIT,
    REG_OUT_GAIN
  } cfg_reg_t;

  typedef struct packed {
    again_t alpha_one;
    again_t alpha_two;
    lim_t   sat_limit;
    ogain_t out_gain;
  } cfg_t;

  // error section to law section
  typedef struct packed {
    word_t e1;
    word_t virt;
    word_t e2;
    word_t inner;
  } err_t;

  // law section to output section
  typedef struct packed {
    word_t e1;
    word_t virt;
    word_t e2;
    word_t u;
  } law_t;

  localparam word_t  WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t  WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam ctrl_t  CTRL_MAX = {1'b0, {(CTRL_W-1){1'b1}}};
  localparam ctrl_t  CTRL_MIN = {1'b1, {(CTRL_W-1){1'b0}}};
  localparam prod_t  P_BIAS   = prod_t'({FRAC_W{1'b1}});
  localparam yprod_t Y_BIAS   = yprod_t'({FRAC_W{1'b1}});

  // saturate a widened sum to the word range
  function automatic word_t sat_word(input sum_t v);
    logic fits;
    fits = (&v[SUM_W-1:WORD_W-1]) || (~|v[SUM_W-1:WORD_W-1]);
    if (fits) return v[WORD_W-1:0];
    return v[SUM_W-1] ? WORD_MIN : WORD_MAX;
  endfunction

  // drop fraction bits toward zero, then saturate to the word range
  function automatic word_t qscale(input prod_t p);
    prod_t                    b;
    logic [MUL_W-FRAC_W-1:0]  q;
    b = p + (p[MUL_W-1] ? P_BIAS : '0);
    q = b[MUL_W-1:FRAC_W];
    if ((&q[MUL_W-FRAC_W-1:WORD_W-1]) || (~|q[MUL_W-FRAC_W-1:WORD_W-1]))
      return q[WORD_W-1:0];
    return p[MUL_W-1] ? WORD_MIN : WORD_MAX;
  endfunction

  // drop fraction bits toward zero, then saturate to the control range
  function automatic ctrl_t qscale_ctrl(input yprod_t p);
    yprod_t                  b;
    logic [YP_W-FRAC_W-1:0]  q;
    b = p + (p[YP_W-1] ? Y_BIAS : '0);
    q = b[YP_W-1:FRAC_W];
    if ((&q[YP_W-FRAC_W-1:CTRL_W-1]) || (~|q[YP_W-FRAC_W-1:CTRL_W-1]))
      return ctrl_t'(q[CTRL_W-1:0]);
    return p[YP_W-1] ? CTRL_MIN : CTRL_MAX;
  endfunction

endpackage

// ===== hdl/bpc_in_if.sv =====
// Input channel: one sensor sample per beat.
// Depends on bpc_pkg for the word type.
interface bpc_in_if;
  logic           valid;
  logic           ready;
  bpc_pkg::word_t position;
  bpc_pkg::word_t pos_target;
  bpc_pkg::word_t velocity;
  bpc_pkg::word_t vel_target;

  modport source (output valid, position, pos_target, velocity, vel_target,
                  input ready);
  modport sink   (input valid, position, pos_target, velocity, vel_target,
                  output ready);
endinterface

// ===== hdl/bpc_out_if.sv =====
// Result channel: control value and intermediate terms per beat.
// Depends on bpc_pkg for the word and control types.
interface bpc_out_if;
  logic           valid;
  logic           ready;
  bpc_pkg::ctrl_t control_out;
  bpc_pkg::word_t pos_error;
  bpc_pkg::word_t virtual_vel;
  bpc_pkg::word_t vel_error;

  modport source (output valid, control_out, pos_error, virtual_vel, vel_error,
                  input ready);
  modport sink   (input valid, control_out, pos_error, virtual_vel, vel_error,
                  output ready);
endinterface

// ===== hdl/bpc_cfg_if.sv =====
// Configuration write channel: register index and data per beat.
// Depends on bpc_pkg for the index and data widths.
interface bpc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]     index;
  logic [bpc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bpc_err.sv =====
// Error section: position error, alpha_one product, virtual velocity, velocity error
// and the inner term, six register stages. Depends on bpc_pkg.
module bpc_err (
  input  logic            clk,
  input  logic            rst_n,
  input  bpc_pkg::cfg_t   cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  bpc_pkg::word_t  position,
  input  bpc_pkg::word_t  pos_target,
  input  bpc_pkg::word_t  velocity,
  input  bpc_pkg::word_t  vel_target,
  output logic            dn_valid,
  input  logic            dn_ready,
  output bpc_pkg::err_t   dn_data
);
  import bpc_pkg::*;

  logic [ERR_STAGES-1:0] v_r;
  logic [ERR_STAGES-1:0] en;

  word_t s1_e1_r, s1_vel_r, s1_rvel_r, s1_e1_nxt;
  prod_t s2_p1_r, s2_p1_nxt;
  word_t s2_e1_r, s2_vel_r, s2_rvel_r;
  word_t s3_t1_r, s3_e1_r, s3_vel_r, s3_rvel_r, s3_t1_nxt;
  word_t s4_virt_r, s4_e1_r, s4_vel_r, s4_t1_r, s4_virt_nxt;
  word_t s5_e2_r, s5_e1_r, s5_virt_r, s5_t1_r, s5_e2_nxt;
  word_t s6_inner_r, s6_e1_r, s6_virt_r, s6_e2_r, s6_inner_nxt;

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[ERR_STAGES-1] = !v_r[ERR_STAGES-1] || dn_ready;
    for (int i = ERR_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[ERR_STAGES-1];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int i = 1; i < ERR_STAGES; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // datapath next values
  always_comb begin
    s1_e1_nxt    = sat_word(sum_t'(position) - sum_t'(pos_target));
    s2_p1_nxt    = $signed({1'b0, cfg.alpha_one}) * s1_e1_r;
    s3_t1_nxt    = qscale(s2_p1_r);
    s4_virt_nxt  = sat_word(sum_t'(s3_rvel_r) - sum_t'(s3_t1_r));
    s5_e2_nxt    = sat_word(sum_t'(s4_vel_r) - sum_t'(s4_virt_r));
    s6_inner_nxt = sat_word(sum_t'(s5_e2_r) - sum_t'(s5_t1_r));
  end

  // stage 1: position error
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_e1_r   <= s1_e1_nxt;
      s1_vel_r  <= velocity;
      s1_rvel_r <= vel_target;
    end
  end

  // stage 2: alpha_one times e1
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_p1_r   <= s2_p1_nxt;
      s2_e1_r   <= s1_e1_r;
      s2_vel_r  <= s1_vel_r;
      s2_rvel_r <= s1_rvel_r;
    end
  end

  // stage 3: scale and saturate the product
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_t1_r   <= s3_t1_nxt;
      s3_e1_r   <= s2_e1_r;
      s3_vel_r  <= s2_vel_r;
      s3_rvel_r <= s2_rvel_r;
    end
  end

  // stage 4: virtual velocity command
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_virt_r <= s4_virt_nxt;
      s4_e1_r   <= s3_e1_r;
      s4_vel_r  <= s3_vel_r;
      s4_t1_r   <= s3_t1_r;
    end
  end

  // stage 5: velocity error
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_e2_r   <= s5_e2_nxt;
      s5_e1_r   <= s4_e1_r;
      s5_virt_r <= s4_virt_r;
      s5_t1_r   <= s4_t1_r;
    end
  end

  // stage 6: inner term e2 - alpha_one*e1
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_inner_r <= s6_inner_nxt;
      s6_e1_r    <= s5_e1_r;
      s6_virt_r  <= s5_virt_r;
      s6_e2_r    <= s5_e2_r;
    end
  end

  assign dn_data = '{e1: s6_e1_r, virt: s6_virt_r, e2: s6_e2_r, inner: s6_inner_r};

endmodule

// ===== hdl/bpc_law.sv =====
// Law section: both gain products, their scaling and the raw control sum,
// three register stages. Depends on bpc_pkg.
module bpc_law (
  input  logic           clk,
  input  logic           rst_n,
  input  bpc_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  bpc_pkg::err_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output bpc_pkg::law_t  dn_data
);
  import bpc_pkg::*;

  logic [LAW_STAGES-1:0] v_r;
  logic [LAW_STAGES-1:0] en;

  prod_t s7_p2_r, s7_p3_r, s7_p2_nxt, s7_p3_nxt;
  word_t s7_e1_r, s7_virt_r, s7_e2_r;
  word_t s8_t2_r, s8_t3_r, s8_t2_nxt, s8_t3_nxt;
  word_t s8_e1_r, s8_virt_r, s8_e2_r;
  word_t s9_u_r, s9_u_nxt;
  word_t s9_e1_r, s9_virt_r, s9_e2_r;

  // stage enables
  always_comb begin
    en[LAW_STAGES-1] = !v_r[LAW_STAGES-1] || dn_ready;
    for (int i = LAW_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[LAW_STAGES-1];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int i = 1; i < LAW_STAGES; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // datapath next values
  always_comb begin
    s7_p2_nxt = $signed({1'b0, cfg.alpha_one}) * $signed(up_data.inner);
    s7_p3_nxt = $signed({1'b0, cfg.alpha_two}) * $signed(up_data.e2);
    s8_t2_nxt = qscale(s7_p2_r);
    s8_t3_nxt = qscale(s7_p3_r);
    s9_u_nxt  = sat_word(-sum_t'(s8_t2_r) - sum_t'(s8_t3_r) - sum_t'(s8_e1_r));
  end

  // stage 7: gain products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s7_p2_r   <= s7_p2_nxt;
      s7_p3_r   <= s7_p3_nxt;
      s7_e1_r   <= up_data.e1;
      s7_virt_r <= up_data.virt;
      s7_e2_r   <= up_data.e2;
    end
  end

  // stage 8: scale and saturate both products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s8_t2_r   <= s8_t2_nxt;
      s8_t3_r   <= s8_t3_nxt;
      s8_e1_r   <= s7_e1_r;
      s8_virt_r <= s7_virt_r;
      s8_e2_r   <= s7_e2_r;
    end
  end

  // stage 9: raw control value
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s9_u_r    <= s9_u_nxt;
      s9_e1_r   <= s8_e1_r;
      s9_virt_r <= s8_virt_r;
      s9_e2_r   <= s8_e2_r;
    end
  end

  assign dn_data = '{e1: s9_e1_r, virt: s9_virt_r, e2: s9_e2_r, u: s9_u_r};

endmodule

// ===== hdl/bpc_out.sv =====
// Output section: clamp, output gain product and final saturation, three register
// stages; the last stage is the result register. Depends on bpc_pkg.
module bpc_out (
  input  logic            clk,
  input  logic            rst_n,
  input  bpc_pkg::cfg_t   cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  bpc_pkg::law_t   up_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bpc_pkg::ctrl_t  control_out,
  output bpc_pkg::word_t  pos_error,
  output bpc_pkg::word_t  virtual_vel,
  output bpc_pkg::word_t  vel_error
);
  import bpc_pkg::*;

  logic [OUT_STAGES-1:0] v_r;
  logic [OUT_STAGES-1:0] en;

  word_t  lim_w;
  word_t  u_in;
  ctrl_t  s10_uc_r, s10_uc_nxt;
  word_t  s10_e1_r, s10_virt_r, s10_e2_r;
  yprod_t s11_py_r, s11_py_nxt;
  word_t  s11_e1_r, s11_virt_r, s11_e2_r;
  ctrl_t  s12_y_r, s12_y_nxt;
  word_t  s12_e1_r, s12_virt_r, s12_e2_r;

  // stage enables
  always_comb begin
    en[OUT_STAGES-1] = !v_r[OUT_STAGES-1] || out_ready;
    for (int i = OUT_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign up_ready  = en[0];
  assign out_valid = v_r[OUT_STAGES-1];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int i = 1; i < OUT_STAGES; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // clamp to +/- sat_limit; the clamped value always fits the control width
  always_comb begin
    lim_w = word_t'(cfg.sat_limit);
    u_in  = $signed(up_data.u);
    priority if (u_in > lim_w) begin
      s10_uc_nxt = ctrl_t'(cfg.sat_limit);
    end else if (u_in < -lim_w) begin
      s10_uc_nxt = -ctrl_t'(cfg.sat_limit);
    end else begin
      s10_uc_nxt = ctrl_t'(u_in);
    end
    s11_py_nxt = s10_uc_r * $signed(cfg.out_gain);
    s12_y_nxt  = qscale_ctrl(s11_py_r);
  end

  // stage 10: clamp
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s10_uc_r   <= s10_uc_nxt;
      s10_e1_r   <= up_data.e1;
      s10_virt_r <= up_data.virt;
      s10_e2_r   <= up_data.e2;
    end
  end

  // stage 11: output gain product
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s11_py_r   <= s11_py_nxt;
      s11_e1_r   <= s10_e1_r;
      s11_virt_r <= s10_virt_r;
      s11_e2_r   <= s10_e2_r;
    end
  end

  // stage 12: scale, saturate and hold the result beat
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s12_y_r    <= s12_y_nxt;
      s12_e1_r   <= s11_e1_r;
      s12_virt_r <= s11_virt_r;
      s12_e2_r   <= s11_e2_r;
    end
  end

  assign control_out = s12_y_r;
  assign pos_error   = s12_e1_r;
  assign virtual_vel = s12_virt_r;
  assign vel_error   = s12_e2_r;

`ifndef SYNTH
  // clamped value stays inside the symmetric limit
  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> ($signed(s10_uc_r) <= $signed({1'b0, cfg.sat_limit}) &&
                $signed(s10_uc_r) >= -$signed({1'b0, cfg.sat_limit})))
    else $error("clamped control outside sat_limit");

  // a product waiting behind a stalled result is kept
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && v_r[2] && !out_ready) |=> v_r[1])
    else $error("gain stage lost a beat while the result register was stalled");

  // zero output gain gives zero control
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && cfg.out_gain == '0) |-> s12_y_r == '0)
    else $error("nonzero control with zero output gain");
`endif

endmodule

// ===== hdl/backstepping_position_ctrl_unit.sv =====
// Backstepping position controller: twelve-stage pipeline, one sample per beat.
// Each sample passes through the error, law and output sections before its result beat on out_if.
// Throughput: one sample per cycle while out_if is not stalled, set by the pipelined 33x32 gain multipliers.
// A stall on out_if holds each full stage; empty stages keep filling behind it.
// Reset (rst_n low, synchronous) clears all valid bits and the four gain registers.
module backstepping_position_ctrl_unit (
  input logic       clk,
  input logic       rst_n,
  bpc_in_if.sink    in_if,
  bpc_out_if.source out_if,
  bpc_cfg_if.sink   cfg_if
);
  import bpc_pkg::*;

  cfg_t  cfg_r;
  logic  err_valid, err_ready;
  err_t  err_data;
  logic  law_valid, law_ready;
  law_t  law_data;

  // configuration writes are always taken
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_ALPHA_ONE: cfg_r.alpha_one <= cfg_if.data[GAIN_A_W-1:0];
        REG_ALPHA_TWO: cfg_r.alpha_two <= cfg_if.data[GAIN_A_W-1:0];
        REG_SAT_LIMIT: cfg_r.sat_limit <= cfg_if.data[LIM_W-1:0];
        REG_OUT_GAIN:  cfg_r.out_gain  <= cfg_if.data[OG_W-1:0];
      endcase
    end
  end

  // error terms
  bpc_err u_err (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .up_valid     (in_if.valid),
    .up_ready     (in_if.ready),
    .position     (in_if.position),
    .pos_target   (in_if.pos_target),
    .velocity     (in_if.velocity),
    .vel_target   (in_if.vel_target),
    .dn_valid     (err_valid),
    .dn_ready     (err_ready),
    .dn_data      (err_data)
  );

  // control law
  bpc_law u_law (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (err_valid),
    .up_ready (err_ready),
    .up_data  (err_data),
    .dn_valid (law_valid),
    .dn_ready (law_ready),
    .dn_data  (law_data)
  );

  // clamp, gain and result register
  bpc_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .up_valid    (law_valid),
    .up_ready    (law_ready),
    .up_data     (law_data),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .control_out (out_if.control_out),
    .pos_error   (out_if.pos_error),
    .virtual_vel (out_if.virtual_vel),
    .vel_error   (out_if.vel_error)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for backstepping_position_ctrl_unit: random and directed samples,
// gain reloads between batches, and a per-sample predictor of the fixed-point control law.
// Depends on bpc_pkg and the bpc_in_if, bpc_out_if and bpc_cfg_if interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int PIPE_LATENCY     = 12;
  localparam int IDLE_LIMIT       = 5000;
  localparam int RX_HOLD_CYCLES   = 400;
  localparam int BATCH_LEN        = 50;
  localparam int BATCHES_PER_MODE = 5;
  localparam int REPORT_LIMIT     = 10;

  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;
  localparam longint CTRL_HI = 64'sd131071;
  localparam longint CTRL_LO = -64'sd131072;

  typedef struct packed {
    word_t position;
    word_t pos_target;
    word_t velocity;
    word_t vel_target;
  } sample_t;

  typedef struct packed {
    ctrl_t control_out;
    word_t pos_error;
    word_t virtual_vel;
    word_t vel_error;
  } control_t;

  typedef struct packed {
    cfg_reg_t                idx;
    logic [CFG_DATA_W-1:0]   data;
  } reg_write_t;

  logic clk;
  logic rst_n;

  bpc_in_if  in_ch();
  bpc_out_if out_ch();
  bpc_cfg_if cfg_ch();

  backstepping_position_ctrl_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // bench copy of the gain registers
  again_t gain_alpha_one = '0;
  again_t gain_alpha_two = '0;
  lim_t   gain_sat_limit = '0;
  ogain_t gain_out       = '0;

  sample_t    pending_samples[$];
  control_t   due_controls[$];
  reg_write_t reg_writes[$];

  sample_t    taken;
  control_t   head;
  reg_write_t next_write;

  int samples_queued     = 0;
  int samples_taken      = 0;
  int results_checked    = 0;
  int writes_queued      = 0;
  int writes_done        = 0;
  int gain_settings      = 0;
  int control_mismatches = 0;
  int idle_cycles        = 0;
  int send_idle_pct      = 0;
  int recv_stall_pct     = 0;
  int send_modes[4]      = '{0, 77, 0, 25};
  int recv_modes[4]      = '{0, 0, 77, 25};

  logic rx_holding = 1'b0;
  event start_rx_hold;

  // clamp to the signed word range
  function automatic longint clip_word(longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // exact Q product, truncated toward zero, saturated to the word
  function automatic longint fixed_mul(longint a, longint b);
    logic signed [95:0] wa, wb, prod;
    logic [95:0]        mag;
    longint             q;
    wa   = a;
    wb   = b;
    prod = wa * wb;
    mag  = prod[95] ? -prod : prod;
    q    = longint'(mag >> FRAC_W);
    return clip_word(prod[95] ? -q : q);
  endfunction

  // backstepping law for one sample under the current gains
  function automatic control_t predict_control(sample_t s);
    longint   p, rp, v, rv, a1, a2, lim, g;
    longint   e1, t1, virt, e2, inner, t2, t3, u, y;
    control_t r;
    p   = s.position;
    rp  = s.pos_target;
    v   = s.velocity;
    rv  = s.vel_target;
    a1  = gain_alpha_one;
    a2  = gain_alpha_two;
    lim = gain_sat_limit;
    g   = gain_out;

    e1    = clip_word(p - rp);
    t1    = fixed_mul(a1, e1);
    virt  = clip_word(rv - t1);
    e2    = clip_word(v - virt);
    inner = clip_word(e2 - t1);
    t2    = fixed_mul(a1, inner);
    t3    = fixed_mul(a2, e2);
    u     = clip_word(-t2 - t3 - e1);
    if (u > lim) u = lim;
    else if (u < -lim) u = -lim;

    y = fixed_mul(g, u);
    if (y > CTRL_HI) y = CTRL_HI;
    else if (y < CTRL_LO) y = CTRL_LO;

    r.control_out = ctrl_t'(y);
    r.pos_error   = word_t'(e1);
    r.virtual_vel = word_t'(virt);
    r.vel_error   = word_t'(e2);
    return r;
  endfunction

  function automatic word_t rand_word();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 2) return word_t'($urandom);
    if (k == 2) begin
      case ($urandom_range(3))
        0:       return WORD_MAX;
        1:       return WORD_MIN;
        2:       return '0;
        default: return word_t'(-1);
      endcase
    end
    // within +/- 8.0 so the law does not always saturate
    return word_t'(int'($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
  endfunction

  function automatic again_t rand_alpha();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 7) return again_t'($urandom_range(32'h0004_0000));
    if (k < 9) return again_t'($urandom);
    return $urandom_range(1) ? '1 : '0;
  endfunction

  function automatic lim_t rand_limit();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 7) return lim_t'($urandom_range(32'h0001_0000));
    if (k < 9) return lim_t'($urandom_range(32'h0001_FFFF, 32'h0001_0001));
    return '0;
  endfunction

  function automatic ogain_t rand_out_gain();
    if ($urandom_range(4) == 0) return ogain_t'($urandom);
    return ogain_t'(int'($urandom_range(32'h0002_0000)) - 32'sh0001_0000);
  endfunction

  task automatic flag_mismatch(string what, longint want, longint got);
    control_mismatches++;
    if (control_mismatches <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic add_sample(word_t p, word_t rp, word_t v, word_t rv);
    pending_samples.push_back('{p, rp, v, rv});
    samples_queued++;
  endtask

  // hold until every queued sample has produced its result
  task automatic wait_drained();
    while (results_checked < samples_queued) @(posedge clk);
  endtask

  // reload all four gains with the pipeline empty; upper data bits of the limit and output gain writes are junk
  task automatic load_gains(again_t a1, again_t a2, lim_t lim, ogain_t g);
    logic [CFG_DATA_W-1:0] d;
    wait_drained();
    reg_writes.push_back('{REG_ALPHA_ONE, CFG_DATA_W'(a1)});
    reg_writes.push_back('{REG_ALPHA_TWO, CFG_DATA_W'(a2)});
    d = $urandom;
    d[LIM_W-1:0] = lim;
    reg_writes.push_back('{REG_SAT_LIMIT, d});
    d = $urandom;
    d[OG_W-1:0] = g;
    reg_writes.push_back('{REG_OUT_GAIN, d});
    writes_queued += 4;
    gain_settings++;
    while (writes_done < writes_queued) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken = '{in_ch.position, in_ch.pos_target, in_ch.velocity, in_ch.vel_target};
        due_controls.push_back(predict_control(taken));
        samples_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          taken = pending_samples.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.position   <= taken.position;
          in_ch.pos_target <= taken.pos_target;
          in_ch.velocity   <= taken.velocity;
          in_ch.vel_target <= taken.vel_target;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // register write driver: mirror each accepted write into the bench gains
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid   <= 1'b0;
      gain_alpha_one <= '0;
      gain_alpha_two <= '0;
      gain_sat_limit <= '0;
      gain_out       <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_ALPHA_ONE: gain_alpha_one <= cfg_ch.data[GAIN_A_W-1:0];
          REG_ALPHA_TWO: gain_alpha_two <= cfg_ch.data[GAIN_A_W-1:0];
          REG_SAT_LIMIT: gain_sat_limit <= cfg_ch.data[LIM_W-1:0];
          REG_OUT_GAIN:  gain_out       <= cfg_ch.data[OG_W-1:0];
          default: ;
        endcase
        writes_done++;
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (reg_writes.size() > 0) begin
          next_write = reg_writes.pop_front();
          cfg_ch.valid <= 1'b1;
          cfg_ch.index <= next_write.idx;
          cfg_ch.data  <= next_write.data;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (due_controls.size() == 0) begin
          flag_mismatch("result beat with nothing due", 0, out_ch.control_out);
        end else begin
          head = due_controls.pop_front();
          if (out_ch.control_out !== head.control_out)
            flag_mismatch("control_out", head.control_out, out_ch.control_out);
          if (out_ch.pos_error !== head.pos_error)
            flag_mismatch("pos_error", head.pos_error, out_ch.pos_error);
          if (out_ch.virtual_vel !== head.virtual_vel)
            flag_mismatch("virtual_vel", head.virtual_vel, out_ch.virtual_vel);
          if (out_ch.vel_error !== head.vel_error)
            flag_mismatch("vel_error", head.vel_error, out_ch.vel_error);
        end
      end
      out_ch.ready <= !rx_holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long output hold so the pipeline backs up into the input
  initial begin
    forever begin
      @(start_rx_hold);
      rx_holding <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_holding <= 1'b0;
    end
  end

  // abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no beat moved for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, samples_queued - results_checked);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.position      = '0;
    in_ch.pos_target    = '0;
    in_ch.velocity      = '0;
    in_ch.vel_target    = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains: errors still computed, control forced to zero
    add_sample('0, '0, '0, '0);
    add_sample(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    add_sample(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
    add_sample(word_t'(-1), '0, 32'sh1, word_t'(-1));

    // unit gains but alpha_two at 2.0, clamp at 1.0
    load_gains(32'h0001_0000, 32'h0002_0000, 17'h1_0000, 18'sh1_0000);
    add_sample(32'sh0001_0000, '0, '0, '0);
    add_sample(-32'sh8000, '0, 32'sh4000, 32'sh1000);
    add_sample(32'sh0002_0000, 32'sh0001_8000, -32'sh0001_0000, 32'sh8000);
    add_sample('0, '0, '0, '0);

    // half gain on odd LSB errors: products truncate toward zero
    load_gains(32'h0000_8000, 32'h0000_0001, 17'h1_0000, -18'sh1_0000);
    add_sample(word_t'(-1), '0, '0, '0);
    add_sample(32'sh1, '0, -32'sh3, '0);
    add_sample(-32'sh3, '0, 32'sh5, -32'sh7);

    // full-scale gains and clamp, most negative output gain: everything saturates
    load_gains('1, '1, '1, 18'sh2_0000);
    add_sample(32'sh0001_0000, '0, '0, '0);
    add_sample(-32'sh0001_0000, '0, '0, '0);
    add_sample(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX);
    add_sample(32'sh1, '0, 32'sh1, '0);

    // zero clamp
    load_gains('0, '1, '0, 18'sh1_FFFF);
    add_sample(32'sh0001_0000, '0, '0, '0);
    add_sample(WORD_MIN, '0, WORD_MAX, WORD_MIN);

    // largest positive output gain with the largest clamp
    load_gains(32'h0001_0000, '0, '1, 18'sh1_FFFF);
    add_sample(-32'sh0001_0000, '0, '0, '0);
    add_sample(32'sh0001_0000, '0, '0, '0);

    // random batches under each idle mode, new gains per batch
    for (int m = 0; m < 4; m++) begin
      for (int b = 0; b < BATCHES_PER_MODE; b++) begin
        load_gains(rand_alpha(), rand_alpha(), rand_limit(), rand_out_gain());
        send_idle_pct  = send_modes[m];
        recv_stall_pct = recv_modes[m];
        if (m == 0 && b == 0) -> start_rx_hold;
        repeat (BATCH_LEN) add_sample(rand_word(), rand_word(), rand_word(), rand_word());
      end
    end

    wait_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (due_controls.size() != 0)
      flag_mismatch("results never delivered", due_controls.size(), 0);

    $display("Checked %0d control results from %0d samples under %0d gain settings,",
             results_checked, samples_taken, gain_settings);
    $display("with idle and stall rates up to 77%% and one %0d-cycle output hold.",
             RX_HOLD_CYCLES);
    if (control_mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", control_mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
